// ===== rtl/amef_pkg.sv =====
// ----------------------------------------------------------------------------
// amef_pkg
// Shared widths, register codes, reset values and sequencer states of the
// acceleration median / moving-average / gravity filter.
// ----------------------------------------------------------------------------
package amef_pkg;

  // Default sample width (signed Q10.10).
  localparam int SAMPLE_WIDTH_DEF = 20;

  // Extra fraction bits carried by the smoothed and gravity state.
  localparam int EXTRA_BITS = 12;

  // Register field widths.
  localparam int RATE_W     = 19;
  localparam int ALPHA_W    = 17;
  localparam int SETTLE_W   = 16;
  localparam int COUNT_W    = 16;
  localparam int CFG_DATA_W = 19;
  localparam int CFG_IDX_W  = 2;

  // Averaging weights are Q1.16; a weight above one acts as one.
  localparam int                 ALPHA_SHIFT = 16;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;

  // Sample counter saturation and start-up fill length of the window.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [COUNT_W-1:0] FILL_LEN  = 16'd3;

  // Register reset values.
  localparam logic [RATE_W-1:0]   RATE_LIMIT_RST     = 19'd2048;
  localparam logic [ALPHA_W-1:0]  FAST_ALPHA_RST     = 17'd19661;
  localparam logic [ALPHA_W-1:0]  GRAVITY_ALPHA_RST  = 17'd1311;
  localparam logic [SETTLE_W-1:0] SETTLE_SAMPLES_RST = 16'd50;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_ALPHA     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_ALPHA  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_SAMPLES = 2'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_FAST,
    ST_FAST_WAIT,
    ST_GRAV,
    ST_GRAV_WAIT,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/amef_ema_unit.sv =====
// ----------------------------------------------------------------------------
// amef_ema_unit
// Shared three-stage moving-average step: res = v + round(alpha * (t - v)
// / 65536), ties towards plus infinity. Used once for the fast average and
// once for the gravity average of each item after the averages are seeded.
// ----------------------------------------------------------------------------
module amef_ema_unit
  import amef_pkg::*;
#(
  parameter int DW = 34
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] v,
  input  logic signed [DW-1:0] t,
  input  logic [ALPHA_W-1:0]   alpha,
  output logic                 done,
  output logic signed [DW-1:0] res
);

  localparam int PW = DW + ALPHA_W + 1;

  logic                 vld1;
  logic                 vld2;
  logic signed [DW-1:0] base1;
  logic signed [DW-1:0] base2;
  logic signed [DW-1:0] diff1;
  logic [ALPHA_W-1:0]   weight1;
  logic signed [PW-1:0] prod2;
  logic signed [PW-1:0] rnd_sum;
  logic signed [PW-1:0] rnd_shift;

  // Round half up, then drop the sixteen weight fraction bits.
  assign rnd_sum   = prod2 + PW'(1 << (ALPHA_SHIFT - 1));
  assign rnd_shift = rnd_sum >>> ALPHA_SHIFT;

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      done <= 1'b0;
    end else begin
      vld1 <= start;
      vld2 <= vld1;
      done <= vld2;
    end
  end

  // Difference, product and accumulate stages.
  always_ff @(posedge clk) begin
    if (start) begin
      base1   <= v;
      diff1   <= t - v;
      weight1 <= (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
    end
    if (vld1) begin
      base2 <= base1;
      prod2 <= $signed({1'b0, weight1}) * diff1;
    end
    if (vld2) begin
      res <= base2 + $signed(rnd_shift[DW-1:0]);
    end
  end

endmodule

// ===== rtl/accel_median_ema_gravity_filter.sv =====
// ----------------------------------------------------------------------------
// accel_median_ema_gravity_filter
// The first three items after reset (raw pass and initialisation) give
// their result from ST_PREP. Later items make two passes through the shared
// three-stage unit, in ST_FAST/ST_FAST_WAIT and ST_GRAV/ST_GRAV_WAIT, then
// ST_FINISH; no new item is taken before ST_IDLE. Synchronous reset clears
// the window, count, flags and out_valid and reloads the register defaults.
// ----------------------------------------------------------------------------
module accel_median_ema_gravity_filter
  import amef_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  // Output channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] filtered,
  output logic [SAMPLE_WIDTH-2:0]        motion_level,
  output logic                           warmed_up,
  output logic                           settled
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int EB = EXTRA_BITS;
  localparam int AW = SW + EB;
  localparam int LW = RATE_W + EB;
  localparam int DW = ((AW > LW) ? AW : LW) + 2;

  // Smoothed value limits in the internal format.
  localparam logic signed [DW-1:0] SM_MAX = DW'({1'b0, {(SW-1){1'b1}}, {EB{1'b0}}});
  localparam logic signed [DW-1:0] SM_MIN = {{(DW-AW+1){1'b1}}, {(AW-1){1'b0}}};
  localparam logic [AW:0]          HALF_LSB = (AW+1)'(1 << (EB - 1));

  // Configuration registers.
  logic [RATE_W-1:0]   rate_limit;
  logic [ALPHA_W-1:0]  fast_alpha;
  logic [ALPHA_W-1:0]  gravity_alpha;
  logic [SETTLE_W-1:0] settle_samples;

  // Filter state.
  state_t               state;
  state_t               state_next;
  logic signed [SW-1:0] window [3];
  logic [COUNT_W-1:0]   count;
  logic                 started;
  logic                 gravity_ready;
  logic signed [AW-1:0] smoothed;
  logic signed [AW-1:0] gravity;
  logic signed [DW-1:0] target;

  // Sequencer strobes.
  logic accept;
  logic out_free;
  logic load_raw;
  logic load_init;
  logic load_target;
  logic ema_start;
  logic fast_ld;
  logic grav_ld;
  logic finish_ld;

  // Shared unit operands and result.
  logic signed [DW-1:0] ema_v;
  logic signed [DW-1:0] ema_t;
  logic [ALPHA_W-1:0]   ema_alpha;
  logic                 ema_done;
  logic signed [DW-1:0] ema_res;

  // Datapath signals.
  logic signed [SW-1:0] med_lo;
  logic signed [SW-1:0] med_hi;
  logic signed [SW-1:0] med_mid;
  logic signed [SW-1:0] median;
  logic signed [AW-1:0] med_ext;
  logic signed [DW-1:0] sm_d;
  logic signed [DW-1:0] grav_d;
  logic signed [DW-1:0] tgt_raw;
  logic signed [DW-1:0] lim;
  logic signed [DW-1:0] tgt_diff;
  logic signed [DW-1:0] target_next;
  logic signed [AW-1:0] sm_clamp;
  logic signed [AW:0]   mot_diff;
  logic [AW:0]          mot_abs;
  logic [AW:0]          mot_rnd;
  logic [SW:0]          mot_q;
  logic [SW-2:0]        motion_sat;
  logic signed [AW:0]   filt_rnd;
  logic                 settle_hit;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_limit     <= RATE_LIMIT_RST;
      fast_alpha     <= FAST_ALPHA_RST;
      gravity_alpha  <= GRAVITY_ALPHA_RST;
      settle_samples <= SETTLE_SAMPLES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RATE_LIMIT:     rate_limit     <= cfg_data[RATE_W-1:0];
        CFG_FAST_ALPHA:     fast_alpha     <= cfg_data[ALPHA_W-1:0];
        CFG_GRAVITY_ALPHA:  gravity_alpha  <= cfg_data[ALPHA_W-1:0];
        CFG_SETTLE_SAMPLES: settle_samples <= cfg_data[SETTLE_W-1:0];
      endcase
    end
  end

  // Median of the three window entries.
  always_comb begin
    med_lo  = (window[0] < window[1]) ? window[0] : window[1];
    med_hi  = (window[0] < window[1]) ? window[1] : window[0];
    med_mid = (med_hi < window[2]) ? med_hi : window[2];
    median  = (med_lo > med_mid) ? med_lo : med_mid;
  end

  assign med_ext = {median, {EB{1'b0}}};
  assign sm_d    = {{(DW-AW){smoothed[AW-1]}}, smoothed};
  assign grav_d  = {{(DW-AW){gravity[AW-1]}}, gravity};
  assign tgt_raw = {{(DW-AW){med_ext[AW-1]}}, med_ext};
  assign lim     = {{(DW-LW){1'b0}}, rate_limit, {EB{1'b0}}};

  // Rate limit of the median against the previous smoothed value.
  always_comb begin
    tgt_diff = tgt_raw - sm_d;
    if (tgt_diff > lim) begin
      target_next = sm_d + lim;
    end else if (tgt_diff < -lim) begin
      target_next = sm_d - lim;
    end else begin
      target_next = tgt_raw;
    end
  end

  // Saturation of the fast average to the sample range.
  always_comb begin
    if (ema_res > SM_MAX) begin
      sm_clamp = SM_MAX[AW-1:0];
    end else if (ema_res < SM_MIN) begin
      sm_clamp = SM_MIN[AW-1:0];
    end else begin
      sm_clamp = ema_res[AW-1:0];
    end
  end

  // Motion level: rounded absolute deviation from gravity, saturated.
  always_comb begin
    mot_diff = {smoothed[AW-1], smoothed} - {gravity[AW-1], gravity};
    mot_abs  = mot_diff[AW] ? (AW+1)'(-mot_diff) : mot_diff;
    mot_rnd  = mot_abs + HALF_LSB;
    mot_q    = mot_rnd[AW:EB];
    if (mot_q[SW:SW-1] != 2'b00) begin
      motion_sat = {(SW-1){1'b1}};
    end else begin
      motion_sat = mot_q[SW-2:0];
    end
  end

  // Smoothed value rounded back to the sample format.
  assign filt_rnd   = {smoothed[AW-1], smoothed} + $signed(HALF_LSB);
  assign settle_hit = (count >= settle_samples);

  // Shared unit operand selection.
  assign ema_v     = (state == ST_FAST) ? sm_d : grav_d;
  assign ema_t     = (state == ST_FAST) ? target : sm_d;
  assign ema_alpha = (state == ST_FAST) ? fast_alpha : gravity_alpha;

  amef_ema_unit #(
    .DW (DW)
  ) u_ema (
    .clk   (clk),
    .rst   (rst),
    .start (ema_start),
    .v     (ema_v),
    .t     (ema_t),
    .alpha (ema_alpha),
    .done  (ema_done),
    .res   (ema_res)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and strobes.
  always_comb begin
    state_next  = state;
    load_raw    = 1'b0;
    load_init   = 1'b0;
    load_target = 1'b0;
    ema_start   = 1'b0;
    fast_ld     = 1'b0;
    grav_ld     = 1'b0;
    finish_ld   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (count < FILL_LEN) begin
          if (out_free) begin
            load_raw   = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (!started) begin
          if (out_free) begin
            load_init  = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          load_target = 1'b1;
          state_next  = ST_FAST;
        end
      end
      ST_FAST: begin
        ema_start  = 1'b1;
        state_next = ST_FAST_WAIT;
      end
      ST_FAST_WAIT: begin
        if (ema_done) begin
          fast_ld    = 1'b1;
          state_next = ST_GRAV;
        end
      end
      ST_GRAV: begin
        ema_start  = 1'b1;
        state_next = ST_GRAV_WAIT;
      end
      ST_GRAV_WAIT: begin
        if (ema_done) begin
          grav_ld    = 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          finish_ld  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state: window, count, flags and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        window[i] <= '0;
      end
      count         <= '0;
      started       <= 1'b0;
      gravity_ready <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        window[0] <= window[1];
        window[1] <= window[2];
        window[2] <= sample;
        if (count != COUNT_MAX) begin
          count <= count + 1'b1;
        end
      end
      if (load_init) begin
        started <= 1'b1;
      end
      if (finish_ld && settle_hit) begin
        gravity_ready <= 1'b1;
      end
      if (load_raw || load_init || finish_ld) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Averages, target and output item registers.
  always_ff @(posedge clk) begin
    if (load_init) begin
      smoothed <= med_ext;
      gravity  <= med_ext;
    end
    if (load_target) begin
      target <= target_next;
    end
    if (fast_ld) begin
      smoothed <= sm_clamp;
    end
    if (grav_ld) begin
      gravity <= ema_res[AW-1:0];
    end
    if (load_raw) begin
      filtered     <= window[2];
      motion_level <= '0;
      warmed_up    <= 1'b0;
      settled      <= gravity_ready;
    end
    if (load_init) begin
      filtered     <= median;
      motion_level <= '0;
      warmed_up    <= 1'b1;
      settled      <= gravity_ready;
    end
    if (finish_ld) begin
      filtered     <= filt_rnd[AW-1:EB];
      motion_level <= motion_sat;
      warmed_up    <= 1'b1;
      settled      <= gravity_ready || settle_hit;
    end
  end

  // The averages are only initialised once the window has filled.
  assert property (@(posedge clk) disable iff (rst) started |-> (count >= FILL_LEN))
    else $error("averages initialised before the window filled");

  // Gravity can only count as settled after initialisation.
  assert property (@(posedge clk) disable iff (rst) gravity_ready |-> started)
    else $error("gravity settled before initialisation");

  // The shared unit only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    ema_done |-> ((state == ST_FAST_WAIT) || (state == ST_GRAV_WAIT)))
    else $error("shared unit result outside a wait state");

  // A non-zero motion level only appears on a warmed-up item.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (motion_level != '0)) |-> warmed_up)
    else $error("motion level reported before warm-up");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the acceleration median / moving-average / gravity
// filter. Samples go in over the stalling input channel, and the registers
// are rewritten between phases while the filter is idle. A scoreboard
// predicts every result from the same fixed-point arithmetic and compares
// each item that leaves the block.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import amef_pkg::*;

  localparam int SW           = SAMPLE_WIDTH_DEF;
  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 3;
  localparam int IDLE_CYCLES  = 16;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_ITEMS  = 200;
  localparam int RAND_PHASES  = 6;

  localparam longint SMAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam longint UNIT = longint'(1) <<< EXTRA_BITS;

  localparam logic signed [SW-1:0]  S_HI      = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]  S_LO      = {1'b1, {(SW-1){1'b0}}};
  localparam logic [CFG_DATA_W-1:0] RATE_ALL  = {RATE_W{1'b1}};
  localparam logic [CFG_DATA_W-1:0] ALPHA_ALL = CFG_DATA_W'({ALPHA_W{1'b1}});
  localparam logic [CFG_DATA_W-1:0] SETTLE_ALL = CFG_DATA_W'({SETTLE_W{1'b1}});

  typedef struct {
    logic signed [SW-1:0] filtered;
    logic [SW-2:0]        motion_level;
    logic                 warmed_up;
    logic                 settled;
  } filter_result_t;

  // Predicts the filter output for each accepted sample and checks what the
  // block produces against the oldest prediction.
  class filter_scoreboard;
    longint         rate_limit;
    longint         fast_alpha;
    longint         gravity_alpha;
    longint         settle_samples;
    longint         win[3];
    int             count;
    bit             started;
    bit             gravity_ready;
    longint         smoothed;
    longint         gravity;
    filter_result_t awaited[$];
    int             errors;
    int             results_seen;

    function new();
      rate_limit     = RATE_LIMIT_RST;
      fast_alpha     = FAST_ALPHA_RST;
      gravity_alpha  = GRAVITY_ALPHA_RST;
      settle_samples = SETTLE_SAMPLES_RST;
      foreach (win[i]) win[i] = 0;
      count         = 0;
      started       = 1'b0;
      gravity_ready = 1'b0;
      smoothed      = 0;
      gravity       = 0;
      errors        = 0;
      results_seen  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_RATE_LIMIT:     rate_limit     = val[RATE_W-1:0];
        CFG_FAST_ALPHA:     fast_alpha     = val[ALPHA_W-1:0];
        CFG_GRAVITY_ALPHA:  gravity_alpha  = val[ALPHA_W-1:0];
        CFG_SETTLE_SAMPLES: settle_samples = val[SETTLE_W-1:0];
        default: ;
      endcase
    endfunction

    // Round to nearest with ties towards plus infinity.
    static function longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    static function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    static function longint median3(longint a, longint b, longint c);
      longint lo;
      longint hi;
      longint m;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      m  = (hi < c) ? hi : c;
      return (lo > m) ? lo : m;
    endfunction

    // One step of an exponential average; weights above one act as one.
    static function longint average_step(longint v, longint target, longint alpha);
      longint one_w;
      longint a;
      one_w = ALPHA_ONE;
      a     = (alpha > one_w) ? one_w : alpha;
      return v + round_shift(a * (target - v), ALPHA_SHIFT);
    endfunction

    function void note_sample(logic signed [SW-1:0] x_in);
      longint         x;
      longint         med;
      longint         target;
      longint         lim;
      longint         d;
      longint         f;
      filter_result_t r;
      x = x_in;
      win[0] = win[1];
      win[1] = win[2];
      win[2] = x;
      if (count < COUNT_MAX) count++;

      r.filtered     = x_in;
      r.motion_level = '0;
      r.warmed_up    = 1'b0;
      r.settled      = gravity_ready;

      // While the window fills, samples pass through untouched.
      if (count >= FILL_LEN) begin
        med         = median3(win[0], win[1], win[2]);
        r.warmed_up = 1'b1;
        if (!started) begin
          // The first full window seeds both averages.
          smoothed   = med * UNIT;
          gravity    = med * UNIT;
          started    = 1'b1;
          r.filtered = med[SW-1:0];
        end else begin
          // Limit the step against the previous smoothed value.
          target = med * UNIT;
          lim    = rate_limit * UNIT;
          if (target - smoothed > lim) target = smoothed + lim;
          else if (target - smoothed < -lim) target = smoothed - lim;

          smoothed = clamp(average_step(smoothed, target, fast_alpha),
                           SMIN * UNIT, SMAX * UNIT);
          gravity  = average_step(gravity, smoothed, gravity_alpha);

          d = smoothed - gravity;
          if (d < 0) d = -d;
          d = round_shift(d, EXTRA_BITS);
          if (d > SMAX) d = SMAX;

          if (count >= settle_samples) gravity_ready = 1'b1;

          f              = clamp(round_shift(smoothed, EXTRA_BITS), SMIN, SMAX);
          r.filtered     = f[SW-1:0];
          r.motion_level = d[SW-2:0];
          r.settled      = gravity_ready;
        end
      end
      awaited.push_back(r);
    endfunction

    function void check_result(filter_result_t got);
      filter_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result %0d arrived with no sample awaiting it", results_seen);
        return;
      end
      want = awaited.pop_front();
      if (got.filtered !== want.filtered || got.motion_level !== want.motion_level ||
          got.warmed_up !== want.warmed_up || got.settled !== want.settled) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"result %0d (expected/actual): filtered %0d/%0d ",
                    "motion_level %0d/%0d warmed_up %0b/%0b settled %0b/%0b"},
                   results_seen, want.filtered, got.filtered,
                   want.motion_level, got.motion_level,
                   want.warmed_up, got.warmed_up, want.settled, got.settled);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  // Block ports.
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic signed [SW-1:0]  sample    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [SW-1:0]  filtered;
  logic [SW-2:0]         motion_level;
  logic                  warmed_up;
  logic                  settled;

  filter_scoreboard sb;
  filter_result_t   seen_result;
  bit               quiet      = 1'b1;
  int               drift      = 1024;
  int               stall_hold = 0;
  int               cycles     = 0;

  accel_median_ema_gravity_filter #(.SAMPLE_WIDTH(SW)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .filtered     (filtered),
    .motion_level (motion_level),
    .warmed_up    (warmed_up),
    .settled      (settled)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly short runs, now and then a long one.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 55) return 0;
    return pick_len();
  endfunction

  // Sensor-like samples: a wandering level with noise, lone spikes that the
  // median ought to reject, full-range values and values around zero.
  function automatic logic signed [SW-1:0] pick_sample();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      drift = drift + int'($urandom_range(0, 400)) - 200;
      if (drift > 300000) drift = 300000;
      if (drift < -300000) drift = -300000;
      v = drift + int'($urandom_range(0, 64)) - 32;
    end else if (r < 70) begin
      v = ($urandom_range(0, 1) != 0) ? int'(S_HI) : int'(S_LO);
    end else if (r < 88) begin
      v = int'($urandom());
    end else begin
      v = int'($urandom_range(0, 4)) - 2;
    end
    return v[SW-1:0];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return RATE_ALL;
      2:       return CFG_DATA_W'($urandom());
      default: return CFG_DATA_W'($urandom_range(1, 8192));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_alpha();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_DATA_W'(ALPHA_ONE);
      2:       return CFG_DATA_W'($urandom_range(65537, 131071));
      default: return CFG_DATA_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // Offers one sample and waits until the filter takes it.
  task automatic send_sample(input logic signed [SW-1:0] x);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(x);
  endtask

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic program_filter(input logic [CFG_DATA_W-1:0] rate,
                                input logic [CFG_DATA_W-1:0] fast,
                                input logic [CFG_DATA_W-1:0] grav,
                                input logic [CFG_DATA_W-1:0] settle);
    write_reg(CFG_RATE_LIMIT, rate);
    write_reg(CFG_FAST_ALPHA, fast);
    write_reg(CFG_GRAVITY_ALPHA, grav);
    write_reg(CFG_SETTLE_SAMPLES, settle);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering samples and waits for the filter to drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  // Output side: check every item taken, then decide the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_result.filtered     = filtered;
      seen_result.motion_level = motion_level;
      seen_result.warmed_up    = warmed_up;
      seen_result.settled      = settled;
      sb.check_result(seen_result);
    end
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold != 0) begin
      stall_hold--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall  <= 1'b1;
      stall_hold = pick_len();
    end else begin
      out_stall  <= 1'b0;
      stall_hold = $urandom_range(0, 12);
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic signed [SW-1:0] burst[$];
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A zero settle threshold from the start: the seeding sample must not
    // set the flag, the next one must. The other registers keep their
    // reset values here.
    write_reg(CFG_SETTLE_SAMPLES, '0);
    cfg_valid <= 1'b0;
    quiet = 1'b0;

    // Raw pass-through of extremes, seeding, then rate-limited jumps both ways.
    burst = '{S_HI, S_LO, SW'(0), SW'(-1), S_HI, S_HI, S_HI, S_LO, S_LO, S_LO,
              SW'(1), SW'(1024), SW'(1024)};
    foreach (burst[i]) send_sample(burst[i]);
    wait_idle();

    // No rate limit, weight above one and a frozen gravity estimate: the
    // output swings end to end and the motion level saturates.
    program_filter(RATE_ALL, ALPHA_ALL, '0, SETTLE_ALL);
    burst = '{S_HI, S_HI, S_HI, S_LO, S_LO, S_LO, S_HI, S_HI};
    foreach (burst[i]) send_sample(burst[i]);
    wait_idle();

    // Random phases, each under its own register setting.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) program_filter('0, CFG_DATA_W'(ALPHA_ONE), CFG_DATA_W'(ALPHA_ONE), '0);
      else if (p == 1) program_filter(pick_rate(), '0, '0, SETTLE_ALL);
      else program_filter(pick_rate(), pick_alpha(), pick_alpha(),
                          CFG_DATA_W'($urandom_range(0, 65535)));
      quiet = (p == 2) || ($urandom_range(0, 4) == 0);
      repeat (PHASE_ITEMS) send_sample(pick_sample());
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
